/* sv/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/gbb_pkg.sv */
`default_nettype none

package gbb_pkg;

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_HEADER = 2'd1,
		MODE_BYTE   = 2'd2
	} gbb_mode_t;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_PEN_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_PEN_Y  = 3'd4;

	localparam logic [14:0] IMAGE_WIDTH_RST  = 15'd640;
	localparam logic [14:0] IMAGE_HEIGHT_RST = 15'd480;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam int PIX_PER_BYTE = 8;
	localparam int QUEUE_DEPTH  = 4;

	typedef struct packed {
		gbb_mode_t          mode;
		logic signed [15:0] blit_x;
		logic signed [15:0] blit_y;
		logic signed [15:0] box_x_offset;
		logic signed [15:0] box_y_offset;
		logic [8:0]         box_width;
		logic [8:0]         box_height;
		logic signed [15:0] advance_x;
		logic signed [15:0] advance_y;
		logic [31:0]        fore_color;
		logic [31:0]        back_color;
		logic [7:0]         bitmap_byte;
	} in_item_t;

	typedef struct packed {
		logic [14:0] pixel_x;
		logic [14:0] pixel_y;
		logic [31:0] pixel_color;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [14:0]        image_width;
		logic [14:0]        image_height;
		logic [14:0]        text_height;
		logic signed [15:0] start_pen_x;
		logic signed [15:0] start_pen_y;
	} gbb_cfg_t;

	// One bitmap byte, already clipped: mask bit k marks a write at column x0 + k.
	typedef struct packed {
		logic [14:0]             x0;
		logic [14:0]             y;
		logic [PIX_PER_BYTE-1:0] mask;
		logic [PIX_PER_BYTE-1:0] set;
		logic [31:0]             fore;
		logic [31:0]             back;
	} gbb_job_t;

endpackage

`default_nettype wire

/* sv/gbb_front.sv */
`default_nettype none

module gbb_front import gbb_pkg::*; #(
	parameter int MAX_GLYPH_SIDE = 256,
	parameter int COORD_BITS     = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire gbb_cfg_t cfg,
	input  wire logic     accept,
	input  wire in_item_t item,
	output logic          push,
	output gbb_job_t      job
);

	localparam int PW     = (COORD_BITS > 16) ? COORD_BITS : 16;
	localparam int SW     = PW + 4;
	localparam int SIDE_W = $clog2(MAX_GLYPH_SIDE + 1);
	localparam int BI_W   = $clog2((MAX_GLYPH_SIDE + 7) / 8 + 1);
	localparam logic signed [SW-1:0] SAT_HI =
		SW'((longint'(1) <<< (COORD_BITS - 1)) - longint'(1));
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

	logic signed [PW-1:0] pen_x_q, pen_y_q, origin_x_q, origin_y_q;
	logic signed [15:0]   string_x_q, string_y_q;
	logic [SIDE_W-1:0]    gw_q, gh_q, row_q;
	logic [BI_W-1:0]      byte_q;
	logic [31:0]          fore_q, back_q;

	logic [SIDE_W-1:0]    bw_c, bh_c;
	logic signed [SW-1:0] ox_sum, oy_sum, px_sum, py_sum, y_s;
	logic signed [SW-1:0] x_s [PIX_PER_BYTE];
	logic [31:0]          col_k [PIX_PER_BYTE];
	logic [PIX_PER_BYTE-1:0] mask, set_v;
	logic                 row_in, active, row_end;

	function automatic logic signed [PW-1:0] sat_coord(input logic signed [SW-1:0] v);
		if (v > SAT_HI)
			return PW'(SAT_HI);
		if (v < SAT_LO)
			return PW'(SAT_LO);
		return PW'(v);
	endfunction

	always_comb begin
		bw_c = (32'(item.box_width) > 32'(MAX_GLYPH_SIDE)) ?
			SIDE_W'(MAX_GLYPH_SIDE) : SIDE_W'(item.box_width);
		bh_c = (32'(item.box_height) > 32'(MAX_GLYPH_SIDE)) ?
			SIDE_W'(MAX_GLYPH_SIDE) : SIDE_W'(item.box_height);
		ox_sum = SW'(item.box_x_offset) + SW'(pen_x_q) + SW'(string_x_q);
		oy_sum = $signed(SW'(cfg.text_height))
			- (SW'(item.box_y_offset) + SW'(pen_y_q) + $signed(SW'(bh_c)))
			+ SW'(string_y_q);
		px_sum = SW'(pen_x_q) + SW'(item.advance_x);
		py_sum = SW'(pen_y_q) + SW'(item.advance_y);

		y_s     = SW'(origin_y_q) + $signed(SW'(row_q));
		row_in  = !y_s[SW-1] && (y_s[SW-2:0] < (SW-1)'(cfg.image_height));
		active  = (gw_q != '0) && (gh_q != '0) && (row_q < gh_q);
		row_end = (32'({byte_q, 3'b000}) + 32'd8) >= 32'(gw_q);

		// All eight columns of the byte are clipped side by side.
		for (int k = 0; k < PIX_PER_BYTE; k++) begin
			col_k[k] = 32'({byte_q, 3'b000}) + 32'(k);
			x_s[k]   = SW'(origin_x_q) + $signed(SW'(col_k[k]));
			set_v[k] = item.bitmap_byte[PIX_PER_BYTE-1-k];
			mask[k]  = (col_k[k] < 32'(gw_q)) && row_in && !x_s[k][SW-1]
				&& (x_s[k][SW-2:0] < (SW-1)'(cfg.image_width))
				&& (set_v[k] ? (fore_q[7:0] != ALPHA_OPAQUE)
				             : (back_q[7:0] != ALPHA_OPAQUE));
		end

		push     = accept && (item.mode == MODE_BYTE) && active && (mask != '0);
		job.x0   = x_s[0][14:0];
		job.y    = y_s[14:0];
		job.mask = mask;
		job.set  = set_v;
		job.fore = fore_q;
		job.back = back_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q    <= '0;
			pen_y_q    <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			string_x_q <= '0;
			string_y_q <= '0;
			gw_q       <= '0;
			gh_q       <= '0;
			row_q      <= '0;
			byte_q     <= '0;
			fore_q     <= '0;
			back_q     <= '0;
		end else if (accept) begin
			case (item.mode)
				MODE_START: begin
					string_x_q <= item.blit_x;
					string_y_q <= item.blit_y;
					pen_x_q    <= PW'(cfg.start_pen_x);
					pen_y_q    <= PW'(cfg.start_pen_y);
					gw_q       <= '0;
					gh_q       <= '0;
					row_q      <= '0;
					byte_q     <= '0;
				end
				MODE_HEADER: begin
					origin_x_q <= sat_coord(ox_sum);
					origin_y_q <= sat_coord(oy_sum);
					gw_q       <= bw_c;
					gh_q       <= bh_c;
					fore_q     <= item.fore_color;
					back_q     <= item.back_color;
					row_q      <= '0;
					byte_q     <= '0;
					pen_x_q    <= sat_coord(px_sum);
					pen_y_q    <= sat_coord(py_sum);
				end
				MODE_BYTE: begin
					if (active) begin
						if (row_end) begin
							byte_q <= '0;
							row_q  <= row_q + 1'b1;
						end else begin
							byte_q <= byte_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/gbb_fifo.sv */
`default_nettype none

module gbb_fifo import gbb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire gbb_job_t push_data,
	input  wire logic     pop,
	output logic          full,
	output logic          head_valid,
	output gbb_job_t      head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	gbb_job_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/gbb_back.sv */
`default_nettype none

module gbb_back import gbb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     head_valid,
	input  wire gbb_job_t head,
	output logic          pop,
	input  wire logic     out_stall,
	output logic          out_valid,
	output out_item_t     out_data
);

	logic [PIX_PER_BYTE-1:0] mask_q, set_q;
	logic [14:0]             x0_q, y_q;
	logic [31:0]             fore_q, back_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic [2:0]              idx;
	logic [PIX_PER_BYTE-1:0] rest;
	logic                    out_free, emit, is_last;

	always_comb begin
		idx = '0;
		// Lowest remaining column goes first.
		for (int k = PIX_PER_BYTE - 1; k >= 0; k--) begin
			if (mask_q[k])
				idx = 3'(k);
		end
		rest     = mask_q & ~(PIX_PER_BYTE'(1) << idx);
		is_last  = (rest == '0);
		out_free = !out_valid_q || !out_stall;
		emit     = out_free && (mask_q != '0);
		pop      = head_valid && ((mask_q == '0) || (emit && is_last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				mask_q <= head.mask;
			else if (emit)
				mask_q <= rest;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_free)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			set_q  <= head.set;
			x0_q   <= head.x0;
			y_q    <= head.y;
			fore_q <= head.fore;
			back_q <= head.back;
		end
		if (emit) begin
			out_q.pixel_x     <= x0_q + 15'(idx);
			out_q.pixel_y     <= y_q;
			out_q.pixel_color <= set_q[idx] ? fore_q : back_q;
			out_q.last        <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

/* sv/glyph_bitmap_blitter_unit.sv */
// Glyph bitmap blitter: turns 1-bit glyph bitmaps into clipped RGBA pixel writes.
// Input channel (in_valid/in_stall/in_data) carries start, header and bitmap byte
// items; a transfer happens on an edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall/out_data) carries one pixel write per
// transfer, with last set on the final write of a bitmap byte.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready and must
// only be written while the block is idle.
// The first write of a bitmap byte passes the queue slot, the expander's mask
// register and the output register. Throughput: one pixel write per cycle while
// out_stall is low; a byte gives one write per visible pixel (up to eight). The
// rate is set by the single pixel output port.
// A four-entry queue sits between the classifying front and the pixel expander,
// so bytes keep being taken while the receiver stalls until the queue fills;
// then in_stall rises. A stalled output write holds its value.
// Reset clears the pen, glyph state, queue and output valid and loads the
// default image size of 640 by 480.
`default_nettype none

module glyph_bitmap_blitter_unit import gbb_pkg::*; #(
	parameter int MAX_GLYPH_SIDE = 256,
	parameter int COORD_BITS     = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	gbb_cfg_t cfg_q;
	gbb_job_t job, head;
	logic     accept, push, pop, full, head_valid;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= IMAGE_WIDTH_RST;
			cfg_q.image_height <= IMAGE_HEIGHT_RST;
			cfg_q.text_height  <= '0;
			cfg_q.start_pen_x  <= '0;
			cfg_q.start_pen_y  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[14:0];
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[14:0];
				CFG_TEXT_HEIGHT:  cfg_q.text_height  <= cfg_data[14:0];
				CFG_START_PEN_X:  cfg_q.start_pen_x  <= $signed(cfg_data);
				CFG_START_PEN_Y:  cfg_q.start_pen_y  <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	gbb_front #(
		.MAX_GLYPH_SIDE(MAX_GLYPH_SIDE),
		.COORD_BITS    (COORD_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.accept(accept),
		.item  (in_data),
		.push  (push),
		.job   (job)
	);

	gbb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (job),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head      (head)
	);

	gbb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* sv/gbb_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module gbb_checker import gbb_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);

	// A stalled write must stay put.
	`ASSERT_ON(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled pixel write changed")

	// Nothing leaves the block while reset is applied.
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid, "output valid during reset")

	// The queue is empty after reset, so the first item is never refused.
	`ASSERT_ON(a_ready_after_reset, clk, arst_n, $rose(arst_n) |-> !in_stall, "input stalled right after reset")

	// Writes of one byte come back to back, on one row, left to right.
	`ASSERT_ON(a_byte_run, clk, arst_n, out_valid && !out_stall && !out_data.last |=> out_valid && out_data.pixel_y == $past(out_data.pixel_y) && out_data.pixel_x > $past(out_data.pixel_x), "broken pixel run within a byte")

endmodule

bind glyph_bitmap_blitter_unit gbb_checker u_checker (.*);

`default_nettype wire

/* verif/tb_glyph_bitmap_blitter_unit.sv */
module tb_glyph_bitmap_blitter_unit import gbb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int GLYPH_SIDE_MAX = 256;
	localparam int COORD_MAX = 32767;
	localparam int COORD_MIN = -32768;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		in_item_t  it;
		logic      typed;
		logic      one_px;
		out_item_t px;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	glyph_bitmap_blitter_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the registers and the blit state.
	int img_w, img_h, txt_h, pen0_x, pen0_y;
	int pen_x, pen_y, org_x, org_y, str_x, str_y;
	int glyph_w, glyph_h, row_idx, byte_idx;
	logic [31:0] fore_c, back_c;

	out_item_t pixels_due[$];
	row_t      directed_rows[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int ignored_sent = 0;
	int writes_seen = 0;
	int mismatches = 0;
	int cycle_cnt = 0;
	out_item_t want_px, seen_px;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int sat16(input int v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// Updates the shadow state for one accepted item and, when asked, queues the
	// pixel writes it should cause.
	task automatic blit_item(input in_item_t it, input bit record);
		logic [1:0] m;
		int bx, by, bw, bh, x, y, col;
		bit row_in, bit_set;
		out_item_t px;
		out_item_t row_px[$];
		m = it.mode;
		if (m == MODE_START) begin
			str_x = int'($signed(it.blit_x));
			str_y = int'($signed(it.blit_y));
			pen_x = pen0_x;
			pen_y = pen0_y;
			glyph_w = 0;
			glyph_h = 0;
			row_idx = 0;
			byte_idx = 0;
		end else if (m == MODE_HEADER) begin
			bx = int'($signed(it.box_x_offset));
			by = int'($signed(it.box_y_offset));
			bw = (int'(it.box_width) > GLYPH_SIDE_MAX) ? GLYPH_SIDE_MAX : int'(it.box_width);
			bh = (int'(it.box_height) > GLYPH_SIDE_MAX) ? GLYPH_SIDE_MAX : int'(it.box_height);
			org_x = sat16(bx + pen_x + str_x);
			org_y = sat16(txt_h - (by + pen_y + bh) + str_y);
			glyph_w = bw;
			glyph_h = bh;
			fore_c = it.fore_color;
			back_c = it.back_color;
			row_idx = 0;
			byte_idx = 0;
			pen_x = sat16(pen_x + int'($signed(it.advance_x)));
			pen_y = sat16(pen_y + int'($signed(it.advance_y)));
		end else if (m == MODE_BYTE && glyph_w != 0 && glyph_h != 0
				&& row_idx < glyph_h) begin
			y = org_y + row_idx;
			row_in = (y >= 0) && (y < img_h);
			for (int k = 0; k < PIX_PER_BYTE; k++) begin
				col = byte_idx * PIX_PER_BYTE + k;
				if (col >= glyph_w || !row_in)
					break;
				x = org_x + col;
				if (x < 0 || x >= img_w)
					continue;
				bit_set = it.bitmap_byte[PIX_PER_BYTE - 1 - k];
				if (bit_set ? fore_c[7:0] == ALPHA_OPAQUE : back_c[7:0] == ALPHA_OPAQUE)
					continue;
				px.pixel_x = x[14:0];
				px.pixel_y = y[14:0];
				px.pixel_color = bit_set ? fore_c : back_c;
				px.last = 1'b0;
				row_px = {row_px, px};
			end
			if (row_px.size() > 0)
				row_px[row_px.size() - 1].last = 1'b1;
			if (record)
				foreach (row_px[i])
					pixels_due = {pixels_due, row_px[i]};
			if ((byte_idx + 1) * PIX_PER_BYTE >= glyph_w) begin
				byte_idx = 0;
				row_idx++;
			end else begin
				byte_idx++;
			end
		end
	endtask

	function automatic in_item_t rand_item();
		logic [191:0] r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return in_item_t'(r[$bits(in_item_t)-1:0]);
	endfunction

	function automatic logic [31:0] rand_color();
		logic [31:0] c;
		c = $urandom;
		if ($urandom_range(99) < 20)
			c[7:0] = ALPHA_OPAQUE;
		return c;
	endfunction

	function automatic in_item_t mk_start(input int bx, input int by);
		in_item_t it;
		it = rand_item();
		it.mode = MODE_START;
		it.blit_x = bx[15:0];
		it.blit_y = by[15:0];
		return it;
	endfunction

	function automatic in_item_t mk_header(input int bx, input int by, input int w, input int h,
			input int ax, input int ay, input logic [31:0] fg, input logic [31:0] bg);
		in_item_t it;
		it = rand_item();
		it.mode = MODE_HEADER;
		it.box_x_offset = bx[15:0];
		it.box_y_offset = by[15:0];
		it.box_width = w[8:0];
		it.box_height = h[8:0];
		it.advance_x = ax[15:0];
		it.advance_y = ay[15:0];
		it.fore_color = fg;
		it.back_color = bg;
		return it;
	endfunction

	function automatic in_item_t mk_byte(input logic [7:0] b);
		in_item_t it;
		it = rand_item();
		it.mode = MODE_BYTE;
		it.bitmap_byte = b;
		return it;
	endfunction

	function automatic in_item_t mk_unused();
		in_item_t it;
		it = rand_item();
		it.mode = gbb_mode_t'(MODE_UNUSED);
		return it;
	endfunction

	function automatic row_t plain(input in_item_t it);
		row_t r;
		r = '0;
		r.it = it;
		return r;
	endfunction

	function automatic row_t none(input in_item_t it);
		row_t r;
		r = plain(it);
		r.typed = 1'b1;
		return r;
	endfunction

	function automatic row_t one(input in_item_t it, input int x, input int y,
			input logic [31:0] c);
		row_t r;
		r = none(it);
		r.one_px = 1'b1;
		r.px.pixel_x = x[14:0];
		r.px.pixel_y = y[14:0];
		r.px.pixel_color = c;
		r.px.last = 1'b1;
		return r;
	endfunction

	task automatic add_row(input row_t r);
		directed_rows = {directed_rows, r};
	endtask

	// Blit positions that bring the glyph origin near an edge of the image.
	function automatic int aim_x();
		int a;
		a = $urandom_range(1) ? int'($urandom_range(40)) : img_w - int'($urandom_range(40));
		return sat16(a - pen0_x);
	endfunction

	function automatic int aim_y();
		int a;
		a = $urandom_range(1) ? int'($urandom_range(40)) : img_h - int'($urandom_range(40));
		return sat16(a + pen0_y - txt_h);
	endfunction

	task automatic send_item(input in_item_t it, input bit record);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (in_stall);
		if (it.mode == gbb_mode_t'(MODE_UNUSED))
			ignored_sent++;
		else
			items_sent++;
		blit_item(it, record);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_IMAGE_WIDTH:  img_w = int'(val[14:0]);
			CFG_IMAGE_HEIGHT: img_h = int'(val[14:0]);
			CFG_TEXT_HEIGHT:  txt_h = int'(val[14:0]);
			CFG_START_PEN_X:  pen0_x = int'($signed(val));
			CFG_START_PEN_Y:  pen0_y = int'($signed(val));
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Waits until every queued write has arrived and the block has gone quiet.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic enter_phase(input int iw, input int ih, input int th, input int px,
			input int py, input int snd, input int rcv);
		settle();
		write_reg(CFG_IMAGE_WIDTH, iw[15:0]);
		write_reg(CFG_IMAGE_HEIGHT, ih[15:0]);
		write_reg(CFG_TEXT_HEIGHT, th[15:0]);
		write_reg(CFG_START_PEN_X, px[15:0]);
		write_reg(CFG_START_PEN_Y, py[15:0]);
		send_idle_pct = snd;
		recv_stall_pct = rcv;
	endtask

	// Mostly well-formed strings: a start, then glyphs each followed by its bitmap,
	// with some short or overlong bitmaps and a little noise mixed in.
	task automatic run_random(input int count);
		int goal, pick, w, h, nb;
		in_item_t it;
		logic [7:0] b;
		goal = items_sent + count;
		send_item(mk_start(aim_x(), aim_y()), 1'b1);
		while (items_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				send_item(mk_unused(), 1'b1);
			end else if (pick < 9) begin
				it = rand_item();
				it.mode = gbb_mode_t'($urandom_range(2));
				send_item(it, 1'b1);
			end else begin
				if ($urandom_range(99) < 15)
					send_item(mk_start(aim_x(), aim_y()), 1'b1);
				pick = $urandom_range(99);
				if (pick < 6) begin
					w = $urandom_range(300);
					h = $urandom_range(2);
				end else if (pick < 10) begin
					w = $urandom_range(12);
					h = $urandom_range(511, 250);
				end else begin
					w = $urandom_range(20);
					h = $urandom_range(6);
				end
				send_item(mk_header(int'($urandom_range(12)) - 6, int'($urandom_range(10)) - 8,
					w, h, $urandom_range(10), int'($urandom_range(4)) - 2,
					rand_color(), rand_color()), 1'b1);
				nb = (((w > GLYPH_SIDE_MAX) ? GLYPH_SIDE_MAX : w) + 7) / 8
					* ((h > GLYPH_SIDE_MAX) ? GLYPH_SIDE_MAX : h);
				if (nb > 48)
					nb = 48;
				pick = $urandom_range(99);
				if (pick < 8)
					nb += $urandom_range(3, 1);
				else if (pick < 14 && nb > 0)
					nb = $urandom_range(nb - 1);
				repeat (nb) begin
					case ($urandom_range(3))
						0: b = 8'h00;
						1: b = 8'hFF;
						default: b = 8'($urandom);
					endcase
					send_item(mk_byte(b), 1'b1);
				end
			end
		end
	endtask

	task automatic flag(input string what, input out_item_t e, input out_item_t g);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("write %0d %s: expected x=%0d y=%0d color=%h last=%b",
				writes_seen, what, e.pixel_x, e.pixel_y, e.pixel_color, e.last);
			$display("    got x=%0d y=%0d color=%h last=%b",
				g.pixel_x, g.pixel_y, g.pixel_color, g.last);
		end
	endtask

	always @(negedge clk)
		out_stall = (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_px = out_data;
			if (pixels_due.size() == 0) begin
				flag("with none pending", '0, seen_px);
			end else begin
				want_px = pixels_due.pop_front();
				if (seen_px.pixel_x !== want_px.pixel_x || seen_px.pixel_y !== want_px.pixel_y
						|| seen_px.pixel_color !== want_px.pixel_color
						|| seen_px.last !== want_px.last)
					flag("mismatch", want_px, seen_px);
			end
			writes_seen++;
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_glyph_bitmap_blitter_unit: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b1;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		img_w = int'(IMAGE_WIDTH_RST);
		img_h = int'(IMAGE_HEIGHT_RST);
		txt_h = 0;
		pen0_x = 0;
		pen0_y = 0;
		pen_x = 0;
		pen_y = 0;
		org_x = 0;
		org_y = 0;
		str_x = 0;
		str_y = 0;
		glyph_w = 0;
		glyph_h = 0;
		row_idx = 0;
		byte_idx = 0;
		fore_c = '0;
		back_c = '0;
		// A clean falling edge on the reset clears the block before the first clock.
		#1 arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows run on the reset configuration of 640 by 480.
		add_row(none(mk_byte(8'hFF)));
		add_row(none(mk_unused()));
		add_row(none(mk_start(0, 0)));
		add_row(none(mk_header(0, -1, 1, 1, 0, 0, 32'h11223344, 32'h55667788)));
		add_row(one(mk_byte(8'h80), 0, 0, 32'h11223344));
		add_row(none(mk_header(639, -1, 1, 1, 0, 0, 32'h123456FF, 32'hA5A5A500)));
		add_row(one(mk_byte(8'h00), 639, 0, 32'hA5A5A500));
		add_row(none(mk_byte(8'hFF)));
		add_row(none(mk_header(640, -1, 1, 1, 0, 0, 32'h01020304, 32'h05060708)));
		add_row(none(mk_byte(8'h80)));
		add_row(none(mk_header(0, -1, 8, 1, 0, 0, 32'h000000FF, 32'hFFFFFFFF)));
		add_row(none(mk_byte(8'h5A)));
		add_row(none(mk_header(0, -1, 0, 3, 0, 0, 32'h10203040, 32'h50607080)));
		add_row(none(mk_byte(8'hFF)));
		add_row(none(mk_header(0, -2, 5, 0, 0, 0, 32'h10203040, 32'h50607080)));
		add_row(none(mk_byte(8'hFF)));
		add_row(plain(mk_header(3, -2, 9, 2, 5, 0, 32'hFF000000, 32'h00FF0000)));
		add_row(plain(mk_byte(8'hFF)));
		add_row(plain(mk_byte(8'hFF)));
		add_row(plain(mk_byte(8'h3C)));
		add_row(plain(mk_byte(8'h80)));
		add_row(plain(mk_header(COORD_MIN, COORD_MAX, 511, 511, COORD_MAX,
			COORD_MAX, 32'hDEADBE00, 32'h0000FF7F)));
		add_row(plain(mk_header(COORD_MIN, COORD_MIN, 256, 1, COORD_MIN,
			COORD_MIN, 32'h80808080, 32'h7F7F7F7F)));
		add_row(plain(mk_byte(8'hC3)));
		add_row(plain(mk_start(COORD_MIN, COORD_MAX)));
		add_row(plain(mk_header(COORD_MAX, COORD_MIN, 8, 1, 0, 0,
			32'hFFFFFF00, 32'h00000000)));
		add_row(plain(mk_byte(8'hA5)));
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].it, !directed_rows[i].typed);
			if (directed_rows[i].one_px)
				pixels_due = {pixels_due, directed_rows[i].px};
		end

		// Largest image, glyphs pushed against its edges.
		enter_phase(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0);
		write_reg(CFG_UNUSED, 16'hFFFF);
		run_random(90);
		// One-pixel image with the start pen at opposite extremes.
		enter_phase(1, 1, 0, COORD_MAX, COORD_MIN, 49, 0);
		run_random(55);
		enter_phase(64, 48, 20, -5, 7, 0, 49);
		run_random(110);
		enter_phase(100, 75, 0, COORD_MIN, COORD_MAX, 7, 7);
		run_random(95);

		settle();
		$display("Sent %0d items plus %0d ignored ones over five configurations;",
			items_sent, ignored_sent);
		$display("checked %0d pixel writes in %0d cycles.", writes_seen, cycle_cnt);
		if (mismatches == 0)
			$display("tb_glyph_bitmap_blitter_unit: clean");
		else
			$display("tb_glyph_bitmap_blitter_unit: errors");
		$finish;
	end

endmodule
